/* src/assert_macros.svh */
// Assertion macros shared by the encoder modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define B64E_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`define B64E_NEVER(label, expr, msg) \
  `B64E_ASSERT(label, !(expr), msg)

`endif

/* src/b64e_pkg.sv */
package b64e_pkg;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  typedef struct packed {
    logic [3:0][5:0] sext;
    logic [2:0]      nchars;
    logic            last;
  } group_t;

  function automatic logic [7:0] alphabet(input logic [5:0] v);
    logic [7:0] ch;
    case (v) inside
      [6'd0:6'd25]:  ch = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: ch = 8'h61 + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: ch = 8'h30 + {2'b00, v} - 8'd52;
      6'd62:         ch = 8'h2b;
      default:       ch = 8'h2f;
    endcase
    return ch;
  endfunction

endpackage

/* src/b64e_byte_if.sv */
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* src/b64e_char_if.sv */
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

/* src/base64_stream_encoder.sv */
// Base64 encoder: one byte per input transaction, four characters per group of three bytes.
// The first character of a group is offered once the group has passed the group queue and been loaded by the back end.
// Throughput: one character per cycle while the output is ready; bytes are taken every cycle
// while the group queue has room, so a long message is bounded by the output port.
// Reset (rst_n low, synchronous) empties the pending bytes, the queue and the output.
module base64_stream_encoder #(
  parameter int unsigned FIFO_DEPTH = b64e_pkg::FIFO_DEPTH
) (
  input logic         clk,
  input logic         rst_n,
  b64e_byte_if.sink   in_s,
  b64e_char_if.source out_s
);

  logic             push;
  logic             full;
  logic             pop;
  logic             rd_valid;
  b64e_pkg::group_t wr_grp;
  b64e_pkg::group_t rd_grp;

  b64e_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .full  (full),
    .push  (push),
    .grp   (wr_grp)
  );

  b64e_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (wr_grp),
    .full     (full),
    .pop      (pop),
    .rd_valid (rd_valid),
    .rd_data  (rd_grp)
  );

  b64e_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_valid (rd_valid),
    .rd_data  (rd_grp),
    .pop      (pop),
    .out_s    (out_s)
  );

endmodule

/* src/b64e_fifo.sv */
`include "assert_macros.svh"

module b64e_fifo #(
  parameter int unsigned DEPTH = b64e_pkg::FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  b64e_pkg::group_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             rd_valid,
  output b64e_pkg::group_t rd_data
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  b64e_pkg::group_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `B64E_NEVER(a_no_overflow, push && full, "Group queue written while full.")
  `B64E_NEVER(a_no_underflow, pop && !rd_valid, "Group queue read while empty.")
  `B64E_ASSERT(a_cnt_track, push && !pop |=> cnt_r == CW'($past(cnt_r) + 1'b1), "Queue count lost a push.")

endmodule

/* src/b64e_front.sv */
module b64e_front (
  input  logic             clk,
  input  logic             rst_n,
  b64e_byte_if.sink        in_s,
  input  logic             full,
  output logic             push,
  output b64e_pkg::group_t grp
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] b0_r, b1_r;
  logic [7:0] g0, g1, g2;
  logic       accept;
  logic       hold;

  assign in_s.ready = !full;
  assign accept     = in_s.valid && in_s.ready;
  assign hold       = (cnt_r != 2'd2) && !in_s.in_last;
  assign push       = accept && !hold;

  always_comb begin
    g0 = (cnt_r == 2'd0) ? in_s.in_byte : b0_r;
    g1 = (cnt_r == 2'd0) ? 8'd0 : ((cnt_r == 2'd1) ? in_s.in_byte : b1_r);
    g2 = (cnt_r == 2'd2) ? in_s.in_byte : 8'd0;
    grp.sext[0] = g0[7:2];
    grp.sext[1] = {g0[1:0], g1[7:4]};
    grp.sext[2] = {g1[3:0], g2[7:6]};
    grp.sext[3] = g2[5:0];
    grp.nchars  = {1'b0, cnt_r} + 3'd2;
    grp.last    = in_s.in_last;
    cnt_nxt     = cnt_r;
    if (accept) begin
      cnt_nxt = hold ? cnt_r + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold) begin
      if (cnt_r[0]) begin
        b1_r <= in_s.in_byte;
      end else begin
        b0_r <= in_s.in_byte;
      end
    end
  end

endmodule

/* src/b64e_back.sv */
`include "assert_macros.svh"

module b64e_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_valid,
  input  b64e_pkg::group_t rd_data,
  output logic             pop,
  b64e_char_if.source      out_s
);

  b64e_pkg::group_t grp_r;
  logic [1:0]       idx_r;
  logic             busy_r;
  logic             emit;
  logic             at_end;

  assign emit   = busy_r && out_s.ready;
  assign at_end = (idx_r == 2'd3);
  assign pop    = rd_valid && (!busy_r || (emit && at_end));

  assign out_s.valid    = busy_r;
  assign out_s.out_char = ({1'b0, idx_r} < grp_r.nchars) ?
                          b64e_pkg::alphabet(grp_r.sext[idx_r]) : b64e_pkg::PAD_CHAR;
  assign out_s.out_last = at_end && grp_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (emit) begin
      busy_r <= !at_end;
      idx_r  <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp_r <= rd_data;
    end
  end

  `B64E_NEVER(a_pad_late, busy_r && !idx_r[1] && out_s.out_char == b64e_pkg::PAD_CHAR, "Pad in the first two characters.")
  `B64E_ASSERT(a_idx_step, emit && !at_end |=> busy_r && idx_r == $past(idx_r) + 2'd1, "Character index skipped.")
  `B64E_NEVER(a_nchars_range, busy_r && (grp_r.nchars < 3'd2 || grp_r.nchars > 3'd4), "Bad character count.")

endmodule
